[src/lbrs_pkg.sv]
// Shared constants, types and microprogram table for the letter buffer range sort block.
package lbrs_pkg;

	localparam int BUFFER_LENGTH_DEF = 1024;
	localparam int ALPHABET_SIZE     = 26;

	localparam int REQ_W    = 2;
	localparam int POS_W    = 10;
	localparam int LEN_W    = 11;
	localparam int LETTER_W = 5;
	localparam int CNT_W    = 11;
	localparam int STEP_W   = 4;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SORT  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE     = 4'd0;
	localparam step_t STEP_DECODE   = 4'd1;
	localparam step_t STEP_TST_WR   = 4'd2;
	localparam step_t STEP_TST_RD   = 4'd3;
	localparam step_t STEP_SORT_CLR = 4'd4;
	localparam step_t STEP_CNT      = 4'd5;
	localparam step_t STEP_CNT_LAST = 4'd6;
	localparam step_t STEP_LOAD     = 4'd7;
	localparam step_t STEP_FILL     = 4'd8;
	localparam step_t STEP_NEXTK    = 4'd9;
	localparam step_t STEP_OUT_OK   = 4'd10;
	localparam step_t STEP_WRITE    = 4'd11;
	localparam step_t STEP_READ     = 4'd12;
	localparam step_t STEP_OUT_RD   = 4'd13;
	localparam step_t STEP_ERR      = 4'd14;
	localparam step_t STEP_SPARE    = 4'd15;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_BAD,
		COND_IS_WRITE,
		COND_IS_READ,
		COND_PTR_LT_HI,
		COND_REM_GT1,
		COND_K_NOT_LAST
	} cond_sel_t;

	typedef enum logic [1:0] {
		OSRC_OK,
		OSRC_RD,
		OSRC_ERR
	} out_src_t;

	typedef enum logic {
		WSRC_LETTER,
		WSRC_KEY
	} wr_src_t;

	typedef struct packed {
		logic      take_in;
		logic      wait_in;
		logic      wait_out;
		logic      mem_rd;
		logic      mem_wr;
		wr_src_t   wsel;
		logic      ptr_inc;
		logic      ptr_lo;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      k_init;
		logic      k_step;
		logic      rem_ld;
		logic      fill;
		logic      out_ld;
		out_src_t  out_src;
		cond_sel_t cond;
		step_t     target;
	} ctrl_word_t;

	typedef struct packed {
		logic bad;
		logic is_write;
		logic is_read;
		logic ptr_lt_hi;
		logic rem_gt1;
		logic k_not_last;
		logic out_busy;
	} dp_flags_t;

	// Microprogram ROM
	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t cw;
		cw = '0;
		unique case (step)
			STEP_IDLE: begin
				cw.take_in = 1'b1;
				cw.wait_in = 1'b1;
			end
			STEP_DECODE: begin
				cw.cond   = COND_BAD;
				cw.target = STEP_ERR;
			end
			STEP_TST_WR: begin
				cw.cond   = COND_IS_WRITE;
				cw.target = STEP_WRITE;
			end
			STEP_TST_RD: begin
				cw.cond   = COND_IS_READ;
				cw.target = STEP_READ;
			end
			STEP_SORT_CLR: begin
				cw.cnt_clr = 1'b1;
			end
			STEP_CNT: begin
				cw.mem_rd  = 1'b1;
				cw.ptr_inc = 1'b1;
				cw.cnt_inc = 1'b1;
				cw.cond    = COND_PTR_LT_HI;
				cw.target  = STEP_CNT;
			end
			STEP_CNT_LAST: begin
				cw.cnt_inc = 1'b1;
				cw.ptr_lo  = 1'b1;
				cw.k_init  = 1'b1;
			end
			STEP_LOAD: begin
				cw.rem_ld = 1'b1;
			end
			STEP_FILL: begin
				cw.fill   = 1'b1;
				cw.wsel   = WSRC_KEY;
				cw.cond   = COND_REM_GT1;
				cw.target = STEP_FILL;
			end
			STEP_NEXTK: begin
				cw.k_step = 1'b1;
				cw.cond   = COND_K_NOT_LAST;
				cw.target = STEP_LOAD;
			end
			STEP_OUT_OK: begin
				cw.out_ld   = 1'b1;
				cw.out_src  = OSRC_OK;
				cw.wait_out = 1'b1;
				cw.cond     = COND_ALWAYS;
				cw.target   = STEP_IDLE;
			end
			STEP_WRITE: begin
				cw.mem_wr = 1'b1;
				cw.wsel   = WSRC_LETTER;
				cw.cond   = COND_ALWAYS;
				cw.target = STEP_OUT_OK;
			end
			STEP_READ: begin
				cw.mem_rd = 1'b1;
			end
			STEP_OUT_RD: begin
				cw.out_ld   = 1'b1;
				cw.out_src  = OSRC_RD;
				cw.wait_out = 1'b1;
				cw.cond     = COND_ALWAYS;
				cw.target   = STEP_IDLE;
			end
			STEP_ERR: begin
				cw.out_ld   = 1'b1;
				cw.out_src  = OSRC_ERR;
				cw.wait_out = 1'b1;
				cw.cond     = COND_ALWAYS;
				cw.target   = STEP_IDLE;
			end
			default: begin
				cw.cond   = COND_ALWAYS;
				cw.target = STEP_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

[src/lbrs_sequencer.sv]
// Step counter, microcode lookup and conditional jump logic.
module lbrs_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  lbrs_pkg::dp_flags_t flags,
	output lbrs_pkg::ctrl_word_t cw,
	output logic                fire
);

	lbrs_pkg::step_t upc_q;
	logic            cond_hit;

	assign cw = lbrs_pkg::ucode(upc_q);

	// a step holds while it waits on either channel
	assign fire = !(cw.wait_in && !in_valid) && !(cw.wait_out && flags.out_busy);

	always_comb begin
		unique case (cw.cond)
			lbrs_pkg::COND_NEVER:      cond_hit = 1'b0;
			lbrs_pkg::COND_ALWAYS:     cond_hit = 1'b1;
			lbrs_pkg::COND_BAD:        cond_hit = flags.bad;
			lbrs_pkg::COND_IS_WRITE:   cond_hit = flags.is_write;
			lbrs_pkg::COND_IS_READ:    cond_hit = flags.is_read;
			lbrs_pkg::COND_PTR_LT_HI:  cond_hit = flags.ptr_lt_hi;
			lbrs_pkg::COND_REM_GT1:    cond_hit = flags.rem_gt1;
			lbrs_pkg::COND_K_NOT_LAST: cond_hit = flags.k_not_last;
			default:                   cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= lbrs_pkg::STEP_IDLE;
		end else if (fire) begin
			if (cond_hit) begin
				upc_q <= cw.target;
			end else begin
				upc_q <= upc_q + lbrs_pkg::STEP_W'(1);
			end
		end
	end

endmodule

[src/lbrs_datapath.sv]
// Letter store, letter counters, pointers and result register.
module lbrs_datapath #(
	parameter int BUFFER_LENGTH = lbrs_pkg::BUFFER_LENGTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lbrs_pkg::ctrl_word_t                cw,
	input  logic                                fire,
	input  logic [lbrs_pkg::REQ_W-1:0]          req_type,
	input  logic [lbrs_pkg::POS_W-1:0]          left_pos,
	input  logic [lbrs_pkg::POS_W-1:0]          right_pos,
	input  logic                                descending,
	input  logic [lbrs_pkg::LETTER_W-1:0]       letter_in,
	input  logic                                cfg_valid,
	input  logic [lbrs_pkg::LEN_W-1:0]          cfg_data,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [lbrs_pkg::LETTER_W-1:0]       letter_out,
	output logic                                status,
	output lbrs_pkg::dp_flags_t                 flags
);

	localparam int AW = $clog2(BUFFER_LENGTH);
	localparam int A  = lbrs_pkg::ALPHABET_SIZE;

	logic [lbrs_pkg::LETTER_W-1:0] mem [BUFFER_LENGTH];

	logic [lbrs_pkg::LEN_W-1:0]    len_q;
	logic [lbrs_pkg::REQ_W-1:0]    req_q;
	logic [lbrs_pkg::POS_W-1:0]    lo_q;
	logic [lbrs_pkg::POS_W-1:0]    hi_q;
	logic                          desc_q;
	logic [lbrs_pkg::LETTER_W-1:0] letter_q;
	logic [lbrs_pkg::LEN_W-1:0]    ptr_q;
	logic [lbrs_pkg::LETTER_W-1:0] k_q;
	logic [lbrs_pkg::CNT_W-1:0]    rem_q;
	logic [lbrs_pkg::LETTER_W-1:0] rd_q;
	logic                          rd_pend_q;
	logic [lbrs_pkg::CNT_W-1:0]    cnt_q [A];
	logic                          out_valid_q;
	logic [lbrs_pkg::LETTER_W-1:0] letter_out_q;
	logic                          status_q;

	logic                          rem_nz;
	logic                          we;
	logic                          re;
	logic                          p_inc;
	logic [lbrs_pkg::LETTER_W-1:0] wdata;
	logic                          lo_ok;
	logic                          hi_ok;
	logic                          out_busy;
	logic                          out_fire;

	assign rem_nz   = (rem_q != '0);
	assign we       = fire && (cw.mem_wr || (cw.fill && rem_nz));
	assign re       = fire && cw.mem_rd;
	assign p_inc    = fire && (cw.ptr_inc || (cw.fill && rem_nz));
	assign wdata    = (cw.wsel == lbrs_pkg::WSRC_KEY) ? k_q : letter_q;
	assign out_busy = out_valid_q && out_stall;
	assign out_fire = fire && cw.out_ld;

	// positions must lie below both the active length and the store depth
	assign lo_ok = (lbrs_pkg::LEN_W'(lo_q) < len_q) && (32'(lo_q) < 32'(BUFFER_LENGTH));
	assign hi_ok = (lbrs_pkg::LEN_W'(hi_q) < len_q) && (32'(hi_q) < 32'(BUFFER_LENGTH));

	always_comb begin
		flags.is_write   = (req_q == lbrs_pkg::REQ_WRITE);
		flags.is_read    = (req_q == lbrs_pkg::REQ_READ);
		flags.ptr_lt_hi  = (ptr_q < lbrs_pkg::LEN_W'(hi_q));
		flags.rem_gt1    = (rem_q > lbrs_pkg::CNT_W'(1));
		flags.k_not_last = desc_q ? (k_q != '0) : (k_q != lbrs_pkg::LETTER_W'(A - 1));
		flags.out_busy   = out_busy;
		case (req_q)
			lbrs_pkg::REQ_WRITE: flags.bad = !lo_ok || (letter_q >= lbrs_pkg::LETTER_W'(A));
			lbrs_pkg::REQ_SORT:  flags.bad = (lo_q > hi_q) || !hi_ok;
			lbrs_pkg::REQ_READ:  flags.bad = !lo_ok;
			default:             flags.bad = 1'b1;
		endcase
	end

	// letter store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[AW'(ptr_q)] <= wdata;
		end
		if (re) begin
			rd_q <= mem[AW'(ptr_q)];
		end
	end

	// request capture and sort pointers
	always_ff @(posedge clk) begin
		if (fire && cw.take_in) begin
			req_q    <= req_type;
			lo_q     <= left_pos;
			hi_q     <= right_pos;
			desc_q   <= descending;
			letter_q <= letter_in;
		end
		if (fire && cw.take_in) begin
			ptr_q <= lbrs_pkg::LEN_W'(left_pos);
		end else if (fire && cw.ptr_lo) begin
			ptr_q <= lbrs_pkg::LEN_W'(lo_q);
		end else if (p_inc) begin
			ptr_q <= ptr_q + lbrs_pkg::LEN_W'(1);
		end
		if (fire && cw.k_init) begin
			k_q <= desc_q ? lbrs_pkg::LETTER_W'(A - 1) : '0;
		end else if (fire && cw.k_step) begin
			k_q <= desc_q ? (k_q - lbrs_pkg::LETTER_W'(1)) : (k_q + lbrs_pkg::LETTER_W'(1));
		end
		if (fire && cw.rem_ld) begin
			rem_q <= cnt_q[k_q];
		end else if (fire && cw.fill && rem_nz) begin
			rem_q <= rem_q - lbrs_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= lbrs_pkg::LEN_RESET;
			rd_pend_q <= 1'b0;
			for (int i = 0; i < A; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				len_q <= cfg_data;
			end
			rd_pend_q <= re;
			if (fire && cw.cnt_clr) begin
				for (int i = 0; i < A; i++) begin
					cnt_q[i] <= '0;
				end
			end else if (fire && cw.cnt_inc && rd_pend_q
					&& (rd_q < lbrs_pkg::LETTER_W'(A))) begin
				cnt_q[rd_q] <= cnt_q[rd_q] + lbrs_pkg::CNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			case (cw.out_src)
				lbrs_pkg::OSRC_RD: begin
					letter_out_q <= rd_q;
					status_q     <= 1'b0;
				end
				lbrs_pkg::OSRC_ERR: begin
					letter_out_q <= '0;
					status_q     <= 1'b1;
				end
				default: begin
					letter_out_q <= '0;
					status_q     <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign letter_out = letter_out_q;
	assign status     = status_q;

endmodule

[src/letter_buffer_range_sort_top.sv]
// Top level of the letter buffer with range counting sort.
//
// Channels: the request channel (in_valid/in_stall) carries req_type, left_pos,
// right_pos, descending and letter_in; the result channel (out_valid/out_stall)
// carries letter_out and status, one result transaction per request.
// cfg_valid/cfg_ready/cfg_data writes active_length; cfg_ready is always high,
// writes are expected only while no request is in flight.
// A microcoded sequencer steps a plain datapath; one request is in work at a time.
// A sort makes one pass counting letters at one store read per cycle, then
// rewrites the range at one letter per cycle plus two control steps per letter
// of the alphabet. The single store port sets these rates.
// A new request is taken once the result is in the output register, even if the
// receiver is still stalling it; a stalled result holds its value, and the
// sequencer waits in its output step only if a second result is ready first.
// Reset clears the sequencer, the result valid, the letter counters and sets
// active_length to 1024; the letter store itself is not cleared.
module letter_buffer_range_sort_top #(
	parameter int BUFFER_LENGTH = lbrs_pkg::BUFFER_LENGTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lbrs_pkg::REQ_W-1:0]    req_type,
	input  logic [lbrs_pkg::POS_W-1:0]    left_pos,
	input  logic [lbrs_pkg::POS_W-1:0]    right_pos,
	input  logic                          descending,
	input  logic [lbrs_pkg::LETTER_W-1:0] letter_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lbrs_pkg::LETTER_W-1:0] letter_out,
	output logic                          status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lbrs_pkg::LEN_W-1:0]    cfg_data
);

	lbrs_pkg::ctrl_word_t cw;
	lbrs_pkg::dp_flags_t  flags;
	logic                 fire;

	// requests enter only in the idle step
	assign in_stall  = !cw.take_in;
	assign cfg_ready = 1'b1;

	lbrs_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.flags    (flags),
		.cw       (cw),
		.fire     (fire)
	);

	lbrs_datapath #(
		.BUFFER_LENGTH (BUFFER_LENGTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cw         (cw),
		.fire       (fire),
		.req_type   (req_type),
		.left_pos   (left_pos),
		.right_pos  (right_pos),
		.descending (descending),
		.letter_in  (letter_in),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.letter_out (letter_out),
		.status     (status),
		.flags      (flags)
	);

	// one request in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted on back-to-back cycles");

	// error results never carry a letter
	a_err_no_letter: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (letter_out == '0))
		else $error("error result with nonzero letter");

	// a new result is only produced from a busy (non-idle) step
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

endmodule
